@@ sv/dbcw_pkg.sv @@
// ============================================================================
// dbcw_pkg
// Shared types and constants for the delay-based credit window.
// ============================================================================
`default_nettype none

package dbcw_pkg;

    // Stamp ring geometry
    localparam int RING_SLOTS = 256;
    localparam int RING_AW    = $clog2(RING_SLOTS);

    // Field widths
    localparam int TIME_W   = 32;
    localparam int CREDIT_W = 16;
    localparam int TARGET_W = 24;
    localparam int STEP_W   = 8;
    localparam int Q16_W    = 17;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [Q16_W-1:0] Q16_ONE = 17'h10000;

    // Multiply and divide both run one bit per cycle over the Q16 operand
    localparam int ALU_STEPS = Q16_W;
    localparam int STEP_CNT_W = $clog2(ALU_STEPS);

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SEND = 2'd1;
    localparam logic [1:0] ST_NO_RECV = 2'd2;

    // Item kinds
    localparam logic KIND_SEND  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CREDIT_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEC_FLOOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEND    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_RECV    = 3'd6;

    // Reset values
    localparam logic [TARGET_W-1:0] RST_TARGET_DELAY = 24'd5000;
    localparam logic [CREDIT_W-1:0] RST_CREDIT_LIMIT = 16'd4096;
    localparam logic [STEP_W-1:0]   RST_INC_STEP     = 8'd1;
    localparam logic [Q16_W-1:0]    RST_DEC_FLOOR    = 17'd32768;
    localparam logic [Q16_W-1:0]    RST_DELAY_GAIN   = 17'd52429;
    localparam logic [CREDIT_W-1:0] RST_CREDIT       = 16'd4096;

    typedef struct packed {
        logic              kind;
        logic              management;
        logic [TIME_W-1:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [TIME_W-1:0]   measured_delay;
        logic [CREDIT_W-1:0] send_window;
        logic [CREDIT_W-1:0] recv_window;
    } t_out_item;

endpackage

`default_nettype wire

@@ sv/delay_based_credit_window_top.sv @@
// ============================================================================
// delay_based_credit_window_top
// Delay-driven AIMD send window with send/receive credits and a stamp ring.
// ============================================================================
// The result of a send or management item is loaded into the output
// register at the accepting edge. A reply whose delay is under the target
// passes through ring read, delay compare and result load. A zero delay at a
// zero target skips the multiply and divide. A reply at or over the target
// passes through ring read, delay compare, 17 multiply steps and 17 divide
// steps on one shared 34-bit add/subtract unit, then factor, 17x16 product,
// saturation and result load. The block takes no new item while a reply is
// in progress, nor while a result waits in the output register.
// The stamp ring is a 256 x 32 memory with no clear after reset; a reply must
// only read slots that an earlier granted send wrote.
`default_nettype none

module delay_based_credit_window_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // item input
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  dbcw_pkg::t_in_item             i_in_item,
    // result output
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output dbcw_pkg::t_out_item                  o_out_item,
    // configuration writes
    input  wire                                  i_cfg_we,
    input  wire  [dbcw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [dbcw_pkg::CFG_W-1:0]           i_cfg_data
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DELAY = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FACT  = 3'd4;
    localparam logic [2:0] S_PROD  = 3'd5;
    localparam logic [2:0] S_SAT   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [dbcw_pkg::STEP_CNT_W-1:0] LAST_STEP =
        dbcw_pkg::STEP_CNT_W'(dbcw_pkg::ALU_STEPS - 1);
    localparam logic [dbcw_pkg::RING_AW-1:0] LAST_SLOT =
        dbcw_pkg::RING_AW'(dbcw_pkg::RING_SLOTS - 1);

    // Saturating credit add
    function automatic logic [dbcw_pkg::CREDIT_W-1:0] sat_add(
        input logic [dbcw_pkg::CREDIT_W-1:0] a,
        input logic [dbcw_pkg::STEP_W-1:0]   b
    );
        logic [dbcw_pkg::CREDIT_W:0] s;
        s = {1'b0, a} + {{(dbcw_pkg::CREDIT_W - dbcw_pkg::STEP_W + 1){1'b0}}, b};
        return s[dbcw_pkg::CREDIT_W] ? '1 : s[dbcw_pkg::CREDIT_W-1:0];
    endfunction

    // Configuration registers
    logic [dbcw_pkg::TARGET_W-1:0] r_target;
    logic [dbcw_pkg::CREDIT_W-1:0] r_limit;
    logic [dbcw_pkg::STEP_W-1:0]   r_step;
    logic [dbcw_pkg::Q16_W-1:0]    r_floor;
    logic [dbcw_pkg::Q16_W-1:0]    r_gain;

    // Credit and ring state
    logic [dbcw_pkg::CREDIT_W-1:0] r_send;
    logic [dbcw_pkg::CREDIT_W-1:0] r_recv;
    logic [dbcw_pkg::RING_AW-1:0]  r_head;
    logic [dbcw_pkg::RING_AW-1:0]  r_tail;
    logic [dbcw_pkg::TIME_W-1:0]   r_ring [dbcw_pkg::RING_SLOTS];
    logic [dbcw_pkg::TIME_W-1:0]   r_rd_data;

    // Sequencer and datapath
    logic [2:0]                      r_state;
    logic [dbcw_pkg::STEP_CNT_W-1:0] r_cnt;
    logic [dbcw_pkg::TIME_W-1:0]     r_now;
    logic [dbcw_pkg::TIME_W-1:0]     r_delay;
    logic [dbcw_pkg::TIME_W-1:0]     r_excess;
    logic [dbcw_pkg::TIME_W-1:0]     r_hi;
    logic [dbcw_pkg::Q16_W-1:0]      r_lo;
    logic [dbcw_pkg::Q16_W-1:0]      r_factor;
    logic [dbcw_pkg::CREDIT_W+dbcw_pkg::Q16_W-1:0] r_prod;

    // Output register
    logic                r_out_valid;
    dbcw_pkg::t_out_item r_out_item;

    logic                          w_out_free;
    logic                          w_in_acc;
    logic                          w_grant;
    logic                          w_reply;
    logic [dbcw_pkg::RING_AW-1:0]  n_head;
    logic [dbcw_pkg::RING_AW-1:0]  n_tail;
    logic [dbcw_pkg::TIME_W-1:0]   w_delay;
    logic [dbcw_pkg::TIME_W-1:0]   w_excess;
    logic                          w_under;
    logic [dbcw_pkg::TIME_W:0]     w_op_a;
    logic [dbcw_pkg::TIME_W:0]     w_op_b;
    logic [dbcw_pkg::TIME_W+1:0]   w_alu;
    logic                          w_ge;
    logic [dbcw_pkg::Q16_W-1:0]    w_factor;
    logic [dbcw_pkg::Q16_W-1:0]    w_scaled;

    // Handshake
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_grant     = w_in_acc && !i_in_item.management
                         && (i_in_item.kind == dbcw_pkg::KIND_SEND)
                         && (r_send != '0) && (r_recv != '0);
    assign w_reply     = w_in_acc && !i_in_item.management
                         && (i_in_item.kind == dbcw_pkg::KIND_REPLY);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Ring pointers wrap at the slot count
    assign n_head = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign n_tail = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;

    // Delay and excess over the target
    assign w_delay  = r_now - r_rd_data;
    assign w_excess = w_delay - {{(dbcw_pkg::TIME_W - dbcw_pkg::TARGET_W){1'b0}}, r_target};
    assign w_under  = w_delay < {{(dbcw_pkg::TIME_W - dbcw_pkg::TARGET_W){1'b0}}, r_target};

    // Shared add/subtract unit: shift-add multiply, then restoring divide
    always_comb begin
        if (r_state == S_DIV) begin
            w_op_a = {r_hi, r_lo[dbcw_pkg::Q16_W-1]};
            w_op_b = {1'b0, r_delay};
            w_alu  = {1'b0, w_op_a} - {1'b0, w_op_b};
        end else begin
            w_op_a = {1'b0, r_hi};
            w_op_b = r_lo[0] ? {1'b0, r_excess} : '0;
            w_alu  = {1'b0, w_op_a} + {1'b0, w_op_b};
        end
    end
    assign w_ge = !w_alu[dbcw_pkg::TIME_W+1];

    // Factor = max(1 - term, floor), term clamped at one
    always_comb begin
        if (r_lo >= dbcw_pkg::Q16_ONE) begin
            w_factor = '0;
        end else begin
            w_factor = dbcw_pkg::Q16_ONE - r_lo;
        end
        if (w_factor < r_floor) begin
            w_factor = r_floor;
        end
    end
    assign w_scaled = r_prod[dbcw_pkg::CREDIT_W+dbcw_pkg::Q16_W-1:dbcw_pkg::CREDIT_W];

    // Stamp ring memory
    always_ff @(posedge i_clk) begin
        if (w_grant) begin
            r_ring[r_head] <= i_in_item.now_time;
        end
        if (w_reply) begin
            r_rd_data <= r_ring[r_tail];
        end
    end

    // Datapath registers without reset
    always_ff @(posedge i_clk) begin
        if (w_reply) begin
            r_now <= i_in_item.now_time;
        end
        unique case (r_state)
            S_DELAY: begin
                r_delay  <= w_delay;
                r_excess <= w_excess;
                r_hi     <= '0;
                r_lo     <= (w_delay == '0) ? '0 : r_gain;
            end
            S_MUL: begin
                r_hi <= w_alu[dbcw_pkg::TIME_W:1];
                r_lo <= {w_alu[0], r_lo[dbcw_pkg::Q16_W-1:1]};
            end
            S_DIV: begin
                r_hi <= w_ge ? w_alu[dbcw_pkg::TIME_W-1:0] : w_op_a[dbcw_pkg::TIME_W-1:0];
                r_lo <= {r_lo[dbcw_pkg::Q16_W-2:0], w_ge};
            end
            S_FACT: begin
                r_factor <= w_factor;
            end
            S_PROD: begin
                r_prod <= {{dbcw_pkg::CREDIT_W{1'b0}}, r_factor}
                          * {{dbcw_pkg::Q16_W{1'b0}}, r_send};
            end
            default: begin
            end
        endcase
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_reply) begin
            r_out_item.measured_delay <= '0;
            r_out_item.status         <= dbcw_pkg::ST_OK;
            r_out_item.send_window    <= r_send;
            r_out_item.recv_window    <= r_recv;
            if (w_grant) begin
                r_out_item.send_window <= r_send - 1'b1;
                r_out_item.recv_window <= r_recv - 1'b1;
            end else if (!i_in_item.management) begin
                r_out_item.status <= (r_send == '0) ? dbcw_pkg::ST_NO_SEND
                                                    : dbcw_pkg::ST_NO_RECV;
            end
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_item.status         <= dbcw_pkg::ST_OK;
            r_out_item.measured_delay <= r_delay;
            r_out_item.send_window    <= r_send;
            r_out_item.recv_window    <= r_recv;
        end
    end

    // Control state: sequencer, credits, pointers, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_send      <= dbcw_pkg::RST_CREDIT;
            r_recv      <= dbcw_pkg::RST_CREDIT;
            r_head      <= '0;
            r_tail      <= '0;
            r_target    <= dbcw_pkg::RST_TARGET_DELAY;
            r_limit     <= dbcw_pkg::RST_CREDIT_LIMIT;
            r_step      <= dbcw_pkg::RST_INC_STEP;
            r_floor     <= dbcw_pkg::RST_DEC_FLOOR;
            r_gain      <= dbcw_pkg::RST_DELAY_GAIN;
        end else begin
            // output register
            if (w_in_acc && !w_reply) begin
                r_out_valid <= 1'b1;
            end else if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_grant) begin
                        r_send <= r_send - 1'b1;
                        r_recv <= r_recv - 1'b1;
                        r_head <= n_head;
                    end
                    if (w_reply) begin
                        r_tail  <= n_tail;
                        r_send  <= sat_add(r_send, dbcw_pkg::STEP_W'(1));
                        r_recv  <= sat_add(r_recv, dbcw_pkg::STEP_W'(1));
                        r_state <= S_DELAY;
                    end
                end
                S_DELAY: begin
                    r_cnt <= '0;
                    if (w_under) begin
                        if (r_send < r_limit) begin
                            r_send <= sat_add(r_send, r_step);
                        end
                        r_state <= S_DONE;
                    end else if (w_delay == '0) begin
                        r_state <= S_FACT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_cnt == LAST_STEP) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == LAST_STEP) begin
                        r_cnt   <= '0;
                        r_state <= S_FACT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FACT: begin
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_send  <= w_scaled[dbcw_pkg::CREDIT_W] ? '1
                             : w_scaled[dbcw_pkg::CREDIT_W-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // configuration writes must arrive only while idle; the block does not enforce this
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dbcw_pkg::CFG_TARGET_DELAY: r_target <= i_cfg_data[dbcw_pkg::TARGET_W-1:0];
                    dbcw_pkg::CFG_CREDIT_LIMIT: r_limit  <= i_cfg_data[dbcw_pkg::CREDIT_W-1:0];
                    dbcw_pkg::CFG_INC_STEP:     r_step   <= i_cfg_data[dbcw_pkg::STEP_W-1:0];
                    dbcw_pkg::CFG_DEC_FLOOR:    r_floor  <= i_cfg_data[dbcw_pkg::Q16_W-1:0];
                    dbcw_pkg::CFG_DELAY_GAIN:   r_gain   <= i_cfg_data[dbcw_pkg::Q16_W-1:0];
                    dbcw_pkg::CFG_INIT_SEND:    r_send   <= i_cfg_data[dbcw_pkg::CREDIT_W-1:0];
                    dbcw_pkg::CFG_INIT_RECV:    r_recv   <= i_cfg_data[dbcw_pkg::CREDIT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire
